// ----- hw/rtl/landmark_range_bearing_assert.svh -----
// Assertion macros for the range/bearing block.
`ifndef LANDMARK_RANGE_BEARING_ASSERT_SVH
`define LANDMARK_RANGE_BEARING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lrb_pkg.sv -----
package lrb_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int POS_BITS_DEF     = 16;
  localparam int HEADING_BITS     = 16;
  localparam int GUARD_BITS       = 8;
  localparam int ANGLE_BITS       = 32;
  localparam int ATAN_LEN         = 24;
  localparam int GAIN_BITS        = 30;
  localparam int MUL_SPLIT        = 16;

  // 1/K of the CORDIC, Q30
  localparam logic [GAIN_BITS-1:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic [ANGLE_BITS-1:0] Z_HALF_TURN = 32'h8000_0000;
  localparam logic [ANGLE_BITS-1:0] BEARING_RND = 32'h0000_8000;

  // atan(2^-i), 2^32 = one turn
  localparam logic [ANGLE_BITS-1:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // sideband riding alongside the CORDIC
  typedef struct packed {
    logic                    zero;
    logic [HEADING_BITS-1:0] heading;
  } lrb_tag_t;

endpackage

// ----- hw/rtl/lrb_in_if.sv -----
interface lrb_in_if #(
  parameter int POS_BITS = lrb_pkg::POS_BITS_DEF
) ();
  logic                                  valid;
  logic                                  ready;
  logic signed [POS_BITS-1:0]            particle_x;
  logic signed [POS_BITS-1:0]            particle_y;
  logic signed [lrb_pkg::HEADING_BITS-1:0] particle_heading;
  logic signed [POS_BITS-1:0]            marker_x;
  logic signed [POS_BITS-1:0]            marker_y;

  modport source (
    output valid, particle_x, particle_y, particle_heading, marker_x, marker_y,
    input  ready
  );
  modport sink (
    input  valid, particle_x, particle_y, particle_heading, marker_x, marker_y,
    output ready
  );
endinterface

// ----- hw/rtl/lrb_out_if.sv -----
interface lrb_out_if #(
  parameter int POS_BITS = lrb_pkg::POS_BITS_DEF
) ();
  logic                                    valid;
  logic                                    ready;
  logic [POS_BITS:0]                       range_mm;
  logic signed [lrb_pkg::HEADING_BITS-1:0] bearing;

  modport source (output valid, range_mm, bearing, input ready);
  modport sink (input valid, range_mm, bearing, output ready);
endinterface

// ----- hw/rtl/landmark_range_bearing.sv -----
// Range and bearing from a particle to a known marker, one request per cycle
// while the result side keeps up. Stages: input prep, one register per CORDIC
// step, gain multiply, output register.
// Each stage moves when empty or drained.
// Reset (rst, synchronous): clears the stage valid bits only; data regs keep.
module landmark_range_bearing #(
  parameter int CORDIC_STEPS = lrb_pkg::CORDIC_STEPS_DEF,
  parameter int POS_BITS     = lrb_pkg::POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lrb_in_if.sink     request,
  lrb_out_if.source  result
);
  import lrb_pkg::*;

  `include "landmark_range_bearing_assert.svh"

  localparam int XW        = POS_BITS + GUARD_BITS + 3;  // CORDIC datapath width
  localparam int MAGW      = XW - 1;                     // clamped magnitude
  localparam int XH        = MAGW - MUL_SPLIT;           // upper slice of magnitude
  localparam int PLW       = MUL_SPLIT + GAIN_BITS;
  localparam int PHW       = XH + GAIN_BITS;
  localparam int PW        = MAGW + GAIN_BITS + 1;       // full product plus carry
  localparam int RND_SHIFT = GAIN_BITS + GUARD_BITS;
  localparam int RW        = PW - RND_SHIFT;

  // ---------------------------------------------------------------------------
  // Prep stage: deltas at full width, guard bits, fold the left half plane
  // onto the right with the angle starting at pi, flag coincident points.
  // ---------------------------------------------------------------------------
  logic signed [POS_BITS:0] dx;
  logic signed [POS_BITS:0] dy;
  logic signed [XW-1:0]     gx;
  logic signed [XW-1:0]     gy;
  logic                     cor_ready;

  logic                     prep_v;
  logic signed [XW-1:0]     prep_x;
  logic signed [XW-1:0]     prep_y;
  logic [ANGLE_BITS-1:0]    prep_z;
  lrb_tag_t                 prep_tag;
  logic                     prep_adv;

  assign dx = {request.particle_x[POS_BITS-1], request.particle_x}
            - {request.marker_x[POS_BITS-1], request.marker_x};
  assign dy = {request.particle_y[POS_BITS-1], request.particle_y}
            - {request.marker_y[POS_BITS-1], request.marker_y};

  assign gx = {{(XW-POS_BITS-1-GUARD_BITS){dx[POS_BITS]}}, dx, {GUARD_BITS{1'b0}}};
  assign gy = {{(XW-POS_BITS-1-GUARD_BITS){dy[POS_BITS]}}, dy, {GUARD_BITS{1'b0}}};

  assign prep_adv      = !prep_v || cor_ready;
  assign request.ready = prep_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_v <= 1'b0;
    end else if (prep_adv) begin
      prep_v <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_adv) begin
      if (dx[POS_BITS]) begin
        prep_x <= -gx;
        prep_y <= -gy;
        prep_z <= Z_HALF_TURN;
      end else begin
        prep_x <= gx;
        prep_y <= gy;
        prep_z <= '0;
      end
      prep_tag.zero    <= (dx == '0) && (dy == '0);
      prep_tag.heading <= request.particle_heading;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC vectoring, one micro-rotation per register stage (stages past ATAN_LEN pass through).
  // ---------------------------------------------------------------------------
  logic                  cor_v;
  logic signed [XW-1:0]  cor_x;
  logic [ANGLE_BITS-1:0] cor_z;
  lrb_tag_t              cor_tag;
  logic                  mul_adv;

  lrb_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .POS_BITS     (POS_BITS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_v),
    .in_ready  (cor_ready),
    .in_x      (prep_x),
    .in_y      (prep_y),
    .in_z      (prep_z),
    .in_tag    (prep_tag),
    .out_valid (cor_v),
    .out_ready (mul_adv),
    .out_x     (cor_x),
    .out_z     (cor_z),
    .out_tag   (cor_tag)
  );

  // ---------------------------------------------------------------------------
  // Gain stage: clamp x at zero and multiply by 1/K as two partial products,
  // each well inside a 32x32 multiplier.
  // ---------------------------------------------------------------------------
  logic [MAGW-1:0]       mag;
  logic [MUL_SPLIT-1:0]  mag_lo;
  logic [XH-1:0]         mag_hi;

  logic                  mul_v;
  logic [PLW-1:0]        mul_pl;
  logic [PHW-1:0]        mul_ph;
  logic [ANGLE_BITS-1:0] mul_z;
  lrb_tag_t              mul_tag;
  logic                  out_adv;

  assign mag    = cor_x[XW-1] ? '0 : cor_x[MAGW-1:0];
  assign mag_lo = mag[MUL_SPLIT-1:0];
  assign mag_hi = mag[MAGW-1:MUL_SPLIT];

  assign mul_adv = !mul_v || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (mul_adv) begin
      mul_v <= cor_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_adv) begin
      mul_pl  <= PLW'(mag_lo) * PLW'(INV_GAIN_Q30);
      mul_ph  <= PHW'(mag_hi) * PHW'(INV_GAIN_Q30);
      mul_z   <= cor_z;
      mul_tag <= cor_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: sum partials, round half up, drop guard and fraction,
  // saturate. Bearing is heading minus angle, rounded to 16 bits, wrapping.
  // Coincident points give zero range and zero angle.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]         prod;
  logic [RW-1:0]         rng_full;
  logic [POS_BITS:0]     rng_sat;
  logic [ANGLE_BITS-1:0] z_eff;
  logic [ANGLE_BITS-1:0] diff;

  assign prod = (PW'(mul_ph) << MUL_SPLIT) + PW'(mul_pl)
              + (PW'(1) << (RND_SHIFT - 1));
  assign rng_full = prod[PW-1:RND_SHIFT];
  assign rng_sat  = (|rng_full[RW-1:POS_BITS+1]) ? '1 : rng_full[POS_BITS:0];

  assign z_eff = mul_tag.zero ? '0 : mul_z;
  assign diff  = {mul_tag.heading, {(ANGLE_BITS-HEADING_BITS){1'b0}}} - z_eff
               + BEARING_RND;

  assign out_adv = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_adv) begin
      result.valid <= mul_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      result.range_mm <= mul_tag.zero ? '0 : rng_sat;
      result.bearing  <= diff[ANGLE_BITS-1:ANGLE_BITS-HEADING_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `LRB_ASSERT_NXT(a_prep_hold, clk, rst, prep_v && !cor_ready,
    prep_v && $stable(prep_x) && $stable(prep_tag), "prep stage lost a stalled request")
  `LRB_ASSERT_NXT(a_mul_hold, clk, rst, mul_v && !out_adv,
    mul_v && $stable(mul_pl) && $stable(mul_ph), "gain stage lost a stalled request")
  `LRB_ASSERT_NXT(a_zero_range, clk, rst, mul_v && mul_tag.zero && out_adv,
    result.valid && (result.range_mm == '0), "coincident points gave non-zero range")
  `LRB_ASSERT_IMP(a_ready_chain, clk, rst, !prep_v || (!mul_v && !result.valid && cor_ready),
    request.ready, "request refused with room in the pipe")

endmodule

// ----- hw/rtl/lrb_cordic.sv -----
module lrb_cordic #(
  parameter int CORDIC_STEPS = lrb_pkg::CORDIC_STEPS_DEF,
  parameter int POS_BITS     = lrb_pkg::POS_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  logic signed [POS_BITS+lrb_pkg::GUARD_BITS+2:0]   in_x,
  input  logic signed [POS_BITS+lrb_pkg::GUARD_BITS+2:0]   in_y,
  input  logic [lrb_pkg::ANGLE_BITS-1:0]                   in_z,
  input  lrb_pkg::lrb_tag_t                                in_tag,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output logic signed [POS_BITS+lrb_pkg::GUARD_BITS+2:0]   out_x,
  output logic [lrb_pkg::ANGLE_BITS-1:0]                   out_z,
  output lrb_pkg::lrb_tag_t                                out_tag
);
  import lrb_pkg::*;

  localparam int XW = POS_BITS + GUARD_BITS + 3;

  // index i+1 is the register after step i
  logic signed [XW-1:0]   x   [1:CORDIC_STEPS];
  logic signed [XW-1:0]   y   [1:CORDIC_STEPS];
  logic [ANGLE_BITS-1:0]  z   [1:CORDIC_STEPS];
  lrb_tag_t               tag [1:CORDIC_STEPS];
  logic                   v   [1:CORDIC_STEPS];
  logic                   adv [CORDIC_STEPS];

  assign in_ready = adv[0];

  assign out_valid = v[CORDIC_STEPS];
  assign out_x     = x[CORDIC_STEPS];
  assign out_z     = z[CORDIC_STEPS];
  assign out_tag   = tag[CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0]  x_cur;
    logic signed [XW-1:0]  y_cur;
    logic [ANGLE_BITS-1:0] z_cur;
    lrb_tag_t              tag_cur;
    logic                  v_cur;
    logic signed [XW-1:0]  x_next;
    logic signed [XW-1:0]  y_next;
    logic [ANGLE_BITS-1:0] z_next;

    // stage input: the entry port for the first step, else the previous register
    if (i == 0) begin : g_first
      assign x_cur   = in_x;
      assign y_cur   = in_y;
      assign z_cur   = in_z;
      assign tag_cur = in_tag;
      assign v_cur   = in_valid;
    end else begin : g_chain
      assign x_cur   = x[i];
      assign y_cur   = y[i];
      assign z_cur   = z[i];
      assign tag_cur = tag[i];
      assign v_cur   = v[i];
    end

    // a stage moves when it is empty or the one after it moves
    if (i == CORDIC_STEPS - 1) begin : g_last
      assign adv[i] = !v[i+1] || out_ready;
    end else begin : g_mid
      assign adv[i] = !v[i+1] || adv[i+1];
    end

    if (i < ATAN_LEN) begin : g_rot
      always_comb begin
        if (y_cur[XW-1]) begin
          x_next = x_cur - (y_cur >>> i);
          y_next = y_cur + (x_cur >>> i);
          z_next = z_cur - ATAN_TAB[i];
        end else begin
          x_next = x_cur + (y_cur >>> i);
          y_next = y_cur - (x_cur >>> i);
          z_next = z_cur + ATAN_TAB[i];
        end
      end
    end else begin : g_skip
      assign x_next = x_cur;
      assign y_next = y_cur;
      assign z_next = z_cur;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv[i]) begin
        v[i+1] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        x[i+1]   <= x_next;
        y[i+1]   <= y_next;
        z[i+1]   <= z_next;
        tag[i+1] <= tag_cur;
      end
    end
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrb_pkg::*;

  // Block configuration under test: the package defaults.
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int POS_W = POS_BITS_DEF;
  localparam int LATENCY = STEPS + 3;
  localparam int RANDOM_REQUESTS = 800;
  localparam int QUIET_TAIL = 120;              // last requests run with no idling
  localparam logic [63:0] RANGE_MAX = (64'd1 << (POS_W + 1)) - 64'd1;

  // One request: particle pose plus the marker it is measured against.
  typedef struct packed {
    logic signed [POS_W-1:0]        particle_x;
    logic signed [POS_W-1:0]        particle_y;
    logic signed [HEADING_BITS-1:0] particle_heading;
    logic signed [POS_W-1:0]        marker_x;
    logic signed [POS_W-1:0]        marker_y;
  } landmark_req_t;

  // One sighting: distance and relative bearing to the marker.
  typedef struct packed {
    logic [POS_W:0]                 range_mm;
    logic signed [HEADING_BITS-1:0] bearing;
  } sighting_t;

  // Scoreboard: predicts each sighting as its request is taken and checks the
  // block's results against them strictly in order (the block never reorders).
  class sighting_board;
    sighting_t expected_sightings[$];
    int errors;
    int n_requests;
    int n_checked;
    int n_left_half;
    int n_coincident;

    // Fixed-point CORDIC vectoring, written out step by step so the floor
    // shifts and the 32-bit angle wrap match the hardware exactly.
    function sighting_t predict_range_bearing(landmark_req_t r);
      longint dx, dy, x, y, xs, ys;
      logic [31:0] z;
      logic [63:0] mag, rng;
      logic [31:0] diff;
      sighting_t s;
      dx = longint'(r.particle_x) - longint'(r.marker_x);
      dy = longint'(r.particle_y) - longint'(r.marker_y);
      z = '0;
      rng = '0;
      if (dx != 0 || dy != 0) begin
        x = dx * (longint'(1) << GUARD_BITS);
        y = dy * (longint'(1) << GUARD_BITS);
        // left half plane: fold over and start from half a turn
        if (x < 0) begin
          x = -x;
          y = -y;
          z = Z_HALF_TURN;
        end
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_TAB[i];
          end else begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_TAB[i];
          end
        end
        if (x < 0) x = 0;
        mag = x;
        rng = (mag * 64'(INV_GAIN_Q30) + (64'd1 << (29 + GUARD_BITS))) >> (30 + GUARD_BITS);
        if (rng > RANGE_MAX) rng = RANGE_MAX;
      end
      diff = {r.particle_heading, 16'h0000} - z + BEARING_RND;
      s.range_mm = rng[POS_W:0];
      s.bearing  = diff[31:16];
      return s;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function void note_request(landmark_req_t r);
      n_requests++;
      if (r.particle_x < r.marker_x) n_left_half++;
      if (r.particle_x == r.marker_x && r.particle_y == r.marker_y) n_coincident++;
      expected_sightings.push_back(predict_range_bearing(r));
    endfunction

    task check_result(logic [POS_W:0] range_mm, logic signed [HEADING_BITS-1:0] bearing);
      sighting_t e;
      if (expected_sightings.size() == 0) begin
        report($sformatf("unexpected result range=%0d bearing=%0d", range_mm, bearing));
        return;
      end
      e = expected_sightings.pop_front();
      n_checked++;
      if (range_mm !== e.range_mm)
        report($sformatf("result %0d range_mm got %0d want %0d", n_checked, range_mm, e.range_mm));
      if (bearing !== e.bearing)
        report($sformatf("result %0d bearing got %0d want %0d", n_checked, bearing, e.bearing));
    endtask

    task flush_leftovers();
      while (expected_sightings.size() != 0) begin
        void'(expected_sightings.pop_front());
        report("expected result never arrived");
      end
    endtask
  endclass

  logic clk;
  logic rst;

  lrb_in_if  #(.POS_BITS(POS_W)) request_ch ();
  lrb_out_if #(.POS_BITS(POS_W)) result_ch ();

  landmark_range_bearing #(
    .CORDIC_STEPS(STEPS),
    .POS_BITS    (POS_W)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .request(request_ch),
    .result (result_ch)
  );

  sighting_board sb = new();

  // Idling control shared by the request and result sides. A density of 0
  // means no idling on that side for the current stretch.
  bit idling_on;
  int send_density;
  int stall_density;

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Results are sampled at the edge, so everything seen here is the value
  // from before the edge; all drives are nonblocking.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.range_mm, result_ch.bearing);
  end

  // Result-side back-pressure: ready drops for bursts of random length.
  initial begin
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idling_on && stall_density != 0 && $urandom_range(0, 15) < stall_density) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic landmark_req_t make_req(int px, int py, int hd, int mx, int my);
    landmark_req_t r;
    r.particle_x       = POS_W'(px);
    r.particle_y       = POS_W'(py);
    r.particle_heading = HEADING_BITS'(hd);
    r.marker_x         = POS_W'(mx);
    r.marker_y         = POS_W'(my);
    return r;
  endfunction

  // Mostly markers near the particle (the realistic case, and where small
  // offsets stress the CORDIC), plus full-range pairs and axis, diagonal and coincident cases.
  function automatic landmark_req_t random_req();
    landmark_req_t r;
    int kind;
    int off;
    r.particle_x       = POS_W'($urandom);
    r.particle_y       = POS_W'($urandom);
    r.particle_heading = HEADING_BITS'($urandom);
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      r.marker_x = POS_W'(int'(r.particle_x) - ($urandom_range(0, 4000) - 2000));
      r.marker_y = POS_W'(int'(r.particle_y) - ($urandom_range(0, 4000) - 2000));
    end else if (kind < 9) begin
      r.marker_x = POS_W'($urandom);
      r.marker_y = POS_W'($urandom);
    end else begin
      off = $urandom_range(0, 6000) - 3000;
      case ($urandom_range(0, 3))
        0: begin
          r.marker_x = r.particle_x;
          r.marker_y = POS_W'(int'(r.particle_y) - off);
        end
        1: begin
          r.marker_x = POS_W'(int'(r.particle_x) - off);
          r.marker_y = r.particle_y;
        end
        2: begin
          r.marker_x = POS_W'(int'(r.particle_x) - off);
          r.marker_y = POS_W'(int'(r.particle_y) + off * (($urandom_range(0, 1) * 2) - 1));
        end
        default: begin
          r.marker_x = r.particle_x;
          r.marker_y = r.particle_y;
        end
      endcase
    end
    return r;
  endfunction

  // Present one request and hold it until the block takes it. valid is left
  // high so back-to-back requests need no extra drive.
  task automatic issue_request(landmark_req_t r);
    request_ch.valid            <= 1'b1;
    request_ch.particle_x       <= r.particle_x;
    request_ch.particle_y       <= r.particle_y;
    request_ch.particle_heading <= r.particle_heading;
    request_ch.marker_x         <= r.marker_x;
    request_ch.marker_y         <= r.marker_y;
    do @(posedge clk); while (!request_ch.ready);
    sb.note_request(r);
  endtask

  // Optional gap on the request side after a request has been taken.
  task automatic maybe_gap();
    if (idling_on && send_density != 0 && $urandom_range(0, 15) < send_density) begin
      request_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    landmark_req_t directed[$];
    idling_on     = 1'b1;
    send_density  = 4;
    stall_density = 4;
    rst <= 1'b1;
    request_ch.valid            <= 1'b0;
    request_ch.particle_x       <= '0;
    request_ch.particle_y       <= '0;
    request_ch.particle_heading <= '0;
    request_ch.marker_x         <= '0;
    request_ch.marker_y         <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: coincident points, the widest differences in every
    // direction, left half plane, unit steps and heading extremes.
    directed.push_back(make_req(0, 0, 0, 0, 0));
    directed.push_back(make_req(32767, -32768, 32767, 32767, -32768));
    directed.push_back(make_req(-32768, 32767, -32768, -32768, 32767));
    directed.push_back(make_req(32767, 0, 0, -32768, 0));
    directed.push_back(make_req(-32768, 0, 0, 32767, 0));
    directed.push_back(make_req(0, 32767, 0, 0, -32768));
    directed.push_back(make_req(0, -32768, 0, 0, 32767));
    directed.push_back(make_req(32767, 32767, 16384, -32768, -32768));
    directed.push_back(make_req(-32768, -32768, -16384, 32767, 32767));
    directed.push_back(make_req(-32768, 32767, 32767, 32767, -32768));
    directed.push_back(make_req(32767, -32768, -32768, -32768, 32767));
    directed.push_back(make_req(1, 0, 0, 0, 0));
    directed.push_back(make_req(-1, 0, 0, 0, 0));
    directed.push_back(make_req(0, 1, 0, 0, 0));
    directed.push_back(make_req(0, -1, 0, 0, 0));
    directed.push_back(make_req(1, 1, 0, 0, 0));
    directed.push_back(make_req(-1, -1, 0, 0, 0));
    directed.push_back(make_req(-1, 1, 32767, 0, 0));
    directed.push_back(make_req(-1000, 0, -32768, 0, 0));
    directed.push_back(make_req(-1000, 0, 32767, 0, 0));
    directed.push_back(make_req(5, -3, 12345, 2000, 7000));
    directed.push_back(make_req(-300, 400, -20000, 0, 0));
    foreach (directed[i]) begin
      issue_request(directed[i]);
      maybe_gap();
    end

    // Random part, in stretches of 100 requests each with its own idling
    // mix (sometimes none); the last QUIET_TAIL requests run flat out.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        send_density  = $urandom_range(0, 6);
        stall_density = $urandom_range(0, 6);
      end
      if (n == RANDOM_REQUESTS - QUIET_TAIL) idling_on = 1'b0;
      issue_request(random_req());
      maybe_gap();
    end
    request_ch.valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result.
    while (sb.expected_sightings.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    sb.flush_leftovers();

    $display("covered %0d requests (%0d left half plane, %0d coincident), %0d results checked",
             sb.n_requests, sb.n_left_half, sb.n_coincident, sb.n_checked);
    $display("idling bursts on both sides, flat-out tail, %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
